// ----- hdl/lab_pkg.sv -----
`default_nettype none
package lab_pkg;

  localparam int FRACTION_BITS = 8;

  // Field widths
  localparam int PIX_W = 8;
  localparam int L_W   = 15;
  localparam int AB_W  = 16;

  // Internal fixed point is Q30
  localparam int Q       = 30;
  localparam int LIN_W   = 31;
  localparam int COEF_W  = 24;
  localparam int PROD_W  = LIN_W + COEF_W;
  localparam int NUM_W   = 56;
  localparam int DEN_W   = 24;
  localparam int QUO_W   = 32;
  localparam int CBRT_W  = 31;
  localparam int SQ_W    = 33;
  localparam int CUBE_W  = 35;
  localparam int RAW_W   = 44;
  localparam int OUT_SH  = Q - FRACTION_BITS;

  // Constant divider: divisors lie between 2^23 and 2^24, dividends below 2^54
  localparam int REC_W  = 32;
  localparam int EST_W  = 2 * REC_W;
  localparam int DIV_SH = 22;
  localparam int REC_SH = 54;
  localparam int REM_W  = 27;

  // Pipeline depths
  localparam int DIV_LAT    = 3;
  localparam int CBRT_STEPS = CBRT_W;
  localparam int CIEF_LAT   = 2 * CBRT_STEPS;
  localparam int LINF_DLY   = CIEF_LAT - DIV_LAT - 1;
  localparam int PIPE_LAT   = 3 + DIV_LAT + CIEF_LAT + 2;

  // sRGB to XYZ matrix times 10^7, rows X, Y, Z
  localparam logic [COEF_W-1:0] MAT [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // White point divisors and their rounding halves
  localparam logic [DEN_W-1:0] WHITE_DEN [3] = '{24'd9504560, 24'd10000000, 24'd10887540};
  localparam logic [DEN_W-1:0] WHITE_HALF [3] = '{24'd4752280, 24'd5000000, 24'd5443770};

  // Reciprocals 2^54 / divisor of the white point
  localparam logic [REC_W-1:0] WHITE_REC [3] = '{
    REC_W'((64'd1 << REC_SH) / 64'd9504560),
    REC_W'((64'd1 << REC_SH) / 64'd10000000),
    REC_W'((64'd1 << REC_SH) / 64'd10887540)
  };

  // CIE f() constants; the linear divisor and dividend both carry 2^13
  localparam logic [QUO_W-1:0] F_THR = QUO_W'((64'd8856 << Q) / 64'd1000000);
  localparam logic [13:0]      F_LIN_K = 14'd9033;
  localparam int               F_LIN_SH = 13;
  localparam logic [DEN_W-1:0] F_LIN_D = DEN_W'(1160) << F_LIN_SH;
  localparam logic [REC_W-1:0] F_LIN_REC = REC_W'((64'd1 << REC_SH) / 64'(F_LIN_D));
  localparam logic [NUM_W-1:0] F_LIN_OFS = (NUM_W'(160) << Q) + NUM_W'(580);

  typedef logic [LIN_W-1:0] lin_rom_t [256];

  function automatic logic [63:0] qmul64(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << (Q - 1))) >> Q;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] y);
    logic [63:0] acc;
    acc = qmul64(y, y);
    acc = qmul64(acc, y);
    acc = qmul64(acc, y);
    return qmul64(acc, y);
  endfunction

  function automatic logic [LIN_W-1:0] lin_code(input int unsigned c);
    logic [63:0] c64;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] cand;
    logic [63:0] res;
    c64 = 64'(c & 32'hFF);
    if (c64 * 64'd100000 <= 64'd1031475) begin
      res = (((c64 * 64'd100) << Q) + 64'd164730) / 64'd329460;
    end else begin
      t = (((64'd1000 * c64 + 64'd14025) << Q) + 64'd134512) / 64'd269025;
      s = qmul64(t, t);
      y = '0;
      for (int k = 30; k >= 0; k--) begin
        cand = y | (64'd1 << k);
        if (cand <= (64'd1 << Q) && pow5(cand) <= s) begin
          y = cand;
        end
      end
      res = qmul64(s, y);
    end
    return LIN_W'(res);
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = lin_code(i);
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage
`default_nettype wire

// ----- hdl/lab_ifs.sv -----
`default_nettype none
interface lab_pix_if;
  import lab_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface lab_res_if;
  import lab_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [L_W-1:0]         lightness;
  logic signed [AB_W-1:0] green_red;
  logic signed [AB_W-1:0] blue_yellow;
  modport source (output valid, lightness, green_red, blue_yellow, input ready);
  modport sink (input valid, lightness, green_red, blue_yellow, output ready);
endinterface
`default_nettype wire

// ----- hdl/lab_cdiv.sv -----
`default_nettype none
module lab_cdiv (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [lab_pkg::NUM_W-1:0]   num,
  input  wire logic [lab_pkg::DEN_W-1:0]   den,
  input  wire logic [lab_pkg::REC_W-1:0]   recip,
  output logic      [lab_pkg::QUO_W-1:0]   quo
);
  import lab_pkg::*;

  // Estimate the quotient by reciprocal multiplication (at most two low),
  // then fix it up from the remainder. Three stages.
  logic [REC_W-1:0] num_hi;
  logic [EST_W-1:0] est_full;
  logic [QUO_W-1:0] est_r;
  logic [REM_W-1:0] nlo_r;
  logic [REM_W-1:0] qd_lo;
  logic [QUO_W-1:0] qa_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] den_1;
  logic [REM_W-1:0] den_2;
  logic [1:0]       fix;
  logic [QUO_W-1:0] quo_r;

  assign num_hi   = num[DIV_SH +: REC_W];
  assign est_full = EST_W'(num_hi) * EST_W'(recip);

  // Remainder is below three divisors, so its low bits suffice
  assign qd_lo = est_r[REM_W-1:0] * REM_W'(den);
  assign den_1 = REM_W'(den);
  assign den_2 = REM_W'(den) << 1;
  assign fix   = 2'(rem_r >= den_1) + 2'(rem_r >= den_2);

  always_ff @(posedge clk) begin
    if (en) begin
      est_r <= est_full[EST_W-1:REC_W];
      nlo_r <= num[REM_W-1:0];
      qa_r  <= est_r;
      rem_r <= nlo_r - qd_lo;
      quo_r <= qa_r + QUO_W'(fix);
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// ----- hdl/lab_cief.sv -----
`default_nettype none
module lab_cief (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [lab_pkg::QUO_W-1:0] ratio,
  output logic      [lab_pkg::QUO_W-1:0] f_val
);
  import lab_pkg::*;

  // Above the threshold: cube root search, two stages per result bit
  logic [CBRT_W-1:0] ya_r [CBRT_STEPS];
  logic [SQ_W-1:0]   sq_r [CBRT_STEPS];
  logic [QUO_W-1:0]  ra_r [CBRT_STEPS];
  logic [CBRT_W-1:0] y_r  [CBRT_STEPS];
  logic [QUO_W-1:0]  r_r  [CBRT_STEPS];

  for (genvar j = 0; j < CBRT_STEPS; j++) begin : g_root
    localparam int BIT_POS = CBRT_STEPS - 1 - j;
    logic [CBRT_W-1:0] y_prev;
    logic [QUO_W-1:0]  r_prev;
    logic [CBRT_W-1:0] cand_a;
    logic [CBRT_W-1:0] cand_b;
    logic [SQ_W-1:0]   sq_nxt;
    logic [CUBE_W-1:0] cube;
    logic [CBRT_W-1:0] y_nxt;

    if (j == 0) begin : g_first
      assign y_prev = '0;
      assign r_prev = ratio;
    end else begin : g_next
      assign y_prev = y_r[j-1];
      assign r_prev = r_r[j-1];
    end

    assign cand_a = y_prev | (CBRT_W'(1) << BIT_POS);
    assign sq_nxt = SQ_W'(((63'(cand_a) * 63'(cand_a)) + (63'(1) << (Q - 1))) >> Q);
    assign cand_b = ya_r[j] | (CBRT_W'(1) << BIT_POS);
    assign cube   = CUBE_W'(((65'(sq_r[j]) * 65'(cand_b)) + (65'(1) << (Q - 1))) >> Q);
    assign y_nxt  = (cube <= CUBE_W'(ra_r[j])) ? cand_b : ya_r[j];

    always_ff @(posedge clk) begin
      if (en) begin
        ya_r[j] <= y_prev;
        sq_r[j] <= sq_nxt;
        ra_r[j] <= r_prev;
        y_r[j]  <= y_nxt;
        r_r[j]  <= ra_r[j];
      end
    end
  end

  // Linear segment: (9033 r + 160*2^30 + 580) / 1160, then delay to match the root.
  // Scale dividend and divisor by 2^13 so the divisor suits the constant divider.
  logic [NUM_W-1:0] lnum_r;
  logic [QUO_W-1:0] lquo;
  logic [QUO_W-1:0] ld_r [LINF_DLY];
  logic             big_r [CIEF_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      lnum_r <= (NUM_W'(ratio) * NUM_W'(F_LIN_K) + F_LIN_OFS) << F_LIN_SH;
    end
  end

  lab_cdiv u_lin_div (
    .clk   (clk),
    .en    (en),
    .num   (lnum_r),
    .den   (F_LIN_D),
    .recip (F_LIN_REC),
    .quo   (lquo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r[0]  <= lquo;
      big_r[0] <= ratio > F_THR;
      for (int i = 1; i < LINF_DLY; i++) begin
        ld_r[i] <= ld_r[i-1];
      end
      for (int i = 1; i < CIEF_LAT; i++) begin
        big_r[i] <= big_r[i-1];
      end
    end
  end

  assign f_val = big_r[CIEF_LAT-1] ? QUO_W'(y_r[CBRT_STEPS-1]) : ld_r[LINF_DLY-1];

endmodule
`default_nettype wire

// ----- hdl/srgb_to_cielab_pixel.sv -----
`default_nettype none
// sRGB to CIE L*a*b* (D65) pixel converter.
// in_ch carries one pixel word (red, green, blue, 8-bit sRGB codes); out_ch
// carries one result word (lightness, green_red, blue_yellow): L*, a* and b*
// scaled by 2^FRACTION_BITS; L* saturated to 0..100, a* and b* to field range.
// A word is taken at a rising clk edge where valid and ready are both high.
// Throughput: one pixel word per cycle, with no bubbles, while not stalled.
// The pipeline depth comes from the 3-stage reciprocal divider that normalizes
// by the white point and the 62-stage cube-root search (two stages per result
// bit) in the f() unit. Every stage carries a valid bit alongside its data.
// Stall: when a finished word sits in the output register and the receiver
// holds ready low, the whole pipeline freezes in place (in_ch.ready drops in
// the same cycle); nothing is dropped or repeated. While the output register
// is empty or being drained, a new word is accepted every cycle.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is
// discarded. There is no configuration and no state between pixels.
module srgb_to_cielab_pixel (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lab_pix_if.sink    in_ch,
  lab_res_if.source  out_ch
);
  import lab_pkg::*;

  localparam logic signed [RAW_W-1:0] K116    = RAW_W'(116);
  localparam logic signed [RAW_W-1:0] K500    = RAW_W'(500);
  localparam logic signed [RAW_W-1:0] K200    = RAW_W'(200);
  localparam logic signed [RAW_W-1:0] L_OFS   = RAW_W'(16) << Q;
  localparam logic signed [RAW_W-1:0] RND     = RAW_W'(1) << (OUT_SH - 1);
  localparam logic signed [RAW_W-1:0] L_MAX_S = RAW_W'(100) << FRACTION_BITS;
  localparam logic signed [RAW_W-1:0] AB_MAX_S = RAW_W'(32767);
  localparam logic signed [RAW_W-1:0] AB_MIN_S = -RAW_W'(32768);
  localparam logic [L_W-1:0]          L_MAX_OUT = L_W'(100) << FRACTION_BITS;

  // Advance everything unless a finished word is stuck at the output
  logic en;
  logic out_vld_r;
  logic [PIPE_LAT-2:0] vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[PIPE_LAT-3:0], in_ch.valid};
      out_vld_r <= vld_r[PIPE_LAT-2];
    end
  end

  // Stage 1: linearize each channel from the ROM
  logic [LIN_W-1:0] lin_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= LIN_ROM[in_ch.red];
      lin_r[1] <= LIN_ROM[in_ch.green];
      lin_r[2] <= LIN_ROM[in_ch.blue];
    end
  end

  // Stage 2: matrix products; stage 3: row sums plus rounding half
  logic [PROD_W-1:0] prod_r [3][3];
  logic [NUM_W-1:0]  sum_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int row = 0; row < 3; row++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_r[row][ch] <= PROD_W'(lin_r[ch]) * PROD_W'(MAT[row][ch]);
        end
        sum_r[row] <= NUM_W'(prod_r[row][0]) + NUM_W'(prod_r[row][1])
                    + NUM_W'(prod_r[row][2]) + NUM_W'(WHITE_HALF[row]);
      end
    end
  end

  // Normalize by the white point, then f() per axis
  logic [QUO_W-1:0] ratio [3];
  logic [QUO_W-1:0] f_val [3];

  for (genvar row = 0; row < 3; row++) begin : g_axis
    lab_cdiv u_div (
      .clk   (clk),
      .en    (en),
      .num   (sum_r[row]),
      .den   (WHITE_DEN[row]),
      .recip (WHITE_REC[row]),
      .quo   (ratio[row])
    );

    lab_cief u_f (
      .clk   (clk),
      .en    (en),
      .ratio (ratio[row]),
      .f_val (f_val[row])
    );
  end

  // Combine into L, a, b in Q30
  logic signed [RAW_W-1:0] fx_s;
  logic signed [RAW_W-1:0] fy_s;
  logic signed [RAW_W-1:0] fz_s;
  logic signed [RAW_W-1:0] l_raw_r;
  logic signed [RAW_W-1:0] a_raw_r;
  logic signed [RAW_W-1:0] b_raw_r;

  assign fx_s = signed'(RAW_W'(f_val[0]));
  assign fy_s = signed'(RAW_W'(f_val[1]));
  assign fz_s = signed'(RAW_W'(f_val[2]));

  always_ff @(posedge clk) begin
    if (en) begin
      l_raw_r <= fy_s * K116 - L_OFS;
      a_raw_r <= (fx_s - fy_s) * K500;
      b_raw_r <= (fy_s - fz_s) * K200;
    end
  end

  // Round half up to the output fraction, saturate, hold in the output register
  logic signed [RAW_W-1:0] l_rnd;
  logic signed [RAW_W-1:0] a_rnd;
  logic signed [RAW_W-1:0] b_rnd;
  logic [L_W-1:0]          out_l_nxt;
  logic [AB_W-1:0]         out_a_nxt;
  logic [AB_W-1:0]         out_b_nxt;
  logic [L_W-1:0]          out_l_r;
  logic [AB_W-1:0]         out_a_r;
  logic [AB_W-1:0]         out_b_r;

  assign l_rnd = (l_raw_r + RND) >>> OUT_SH;
  assign a_rnd = (a_raw_r + RND) >>> OUT_SH;
  assign b_rnd = (b_raw_r + RND) >>> OUT_SH;

  always_comb begin
    if (l_rnd < 0) begin
      out_l_nxt = '0;
    end else if (l_rnd > L_MAX_S) begin
      out_l_nxt = L_MAX_OUT;
    end else begin
      out_l_nxt = l_rnd[L_W-1:0];
    end

    if (a_rnd < AB_MIN_S) begin
      out_a_nxt = AB_MIN_S[AB_W-1:0];
    end else if (a_rnd > AB_MAX_S) begin
      out_a_nxt = AB_MAX_S[AB_W-1:0];
    end else begin
      out_a_nxt = a_rnd[AB_W-1:0];
    end

    if (b_rnd < AB_MIN_S) begin
      out_b_nxt = AB_MIN_S[AB_W-1:0];
    end else if (b_rnd > AB_MAX_S) begin
      out_b_nxt = AB_MAX_S[AB_W-1:0];
    end else begin
      out_b_nxt = b_rnd[AB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_l_r <= out_l_nxt;
      out_a_r <= out_a_nxt;
      out_b_r <= out_b_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.lightness   = out_l_r;
  assign out_ch.green_red   = signed'(out_a_r);
  assign out_ch.blue_yellow = signed'(out_b_r);

`ifndef SYNTH
  a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_l_r <= L_MAX_OUT)
    else $error("lightness above its saturation limit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(out_vld_r))
    else $error("pipeline moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && en) |=> vld_r[0])
    else $error("accepted word not tracked in first stage");
`endif

endmodule
`default_nettype wire

// ----- test/lab_tb_ifs.sv -----
`timescale 1ns / 1ps
// The block's interfaces come from the RTL; this file is kept for the form of the
// build and only carries the pixel and Lab word types used by the testbench.
package lab_tb_pkg;
  import lab_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] green_red;
    logic signed [AB_W-1:0] blue_yellow;
  } lab_word_t;
endpackage

// ----- test/srgb_to_cielab_pixel_tb.sv -----
`timescale 1ns / 1ps
module srgb_to_cielab_pixel_tb;
  import lab_pkg::*;
  import lab_tb_pkg::*;

  localparam longint unsigned QUNIT = 64'd1 << 30;
  localparam longint unsigned QMID  = 64'd1 << 29;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PIXELS = 2000;

  // Q30 product, rounded half up
  function automatic longint unsigned qprod(longint unsigned x, longint unsigned y);
    return (x * y + QMID) >> 30;
  endfunction

  // sRGB decode of one 8-bit code to linear Q30
  function automatic longint unsigned srgb_decode(int unsigned code);
    longint unsigned c, t, s, root, cand, p;
    c = code & 8'hFF;
    if (c * 100000 <= 1031475) return ((c * 100 << 30) + 164730) / 329460;
    t = (((1000 * c + 14025) << 30) + 134512) / 269025;
    s = qprod(t, t);
    root = 0;
    for (int k = 30; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      p = qprod(cand, cand);
      p = qprod(p, cand);
      p = qprod(p, cand);
      p = qprod(p, cand);
      if (cand <= QUNIT && p <= s) root = cand;
    end
    return qprod(s, root);
  endfunction

  // CIE companding: cube root above epsilon, linear segment below
  function automatic longint signed lab_compand(longint unsigned r);
    longint unsigned root, cand;
    if (r * 1000000 > 8856 * QUNIT) begin
      root = 0;
      for (int k = 30; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        if (qprod(qprod(cand, cand), cand) <= r) root = cand;
      end
      return root;
    end
    return (9033 * r + 160 * QUNIT + 580) / 1160;
  endfunction

  // Round Q30 half toward +inf down to the output fraction, then clamp
  function automatic longint signed q30_to_field(longint signed v, longint signed lo,
                                                 longint signed hi);
    longint signed r;
    r = (v + (64'sd1 << (OUT_SH - 1))) >>> OUT_SH;
    return r < lo ? lo : (r > hi ? hi : r);
  endfunction

  function automatic lab_word_t convert_pixel(pixel_t px);
    longint unsigned lin [3];
    longint unsigned sx, sy, sz;
    longint signed fx, fy, fz;
    lab_word_t w;
    lin[0] = srgb_decode(px.red);
    lin[1] = srgb_decode(px.green);
    lin[2] = srgb_decode(px.blue);
    sx = 0; sy = 0; sz = 0;
    for (int i = 0; i < 3; i++) begin
      sx += lin[i] * MAT[0][i];
      sy += lin[i] * MAT[1][i];
      sz += lin[i] * MAT[2][i];
    end
    fx = lab_compand((sx + 4752280) / 9504560);
    fy = lab_compand((sy + 5000000) / 10000000);
    fz = lab_compand((sz + 5443770) / 10887540);
    w.lightness   = L_W'(q30_to_field(116 * fy - 16 * longint'(QUNIT), 0,
                                      100 << FRACTION_BITS));
    w.green_red   = AB_W'(q30_to_field(500 * (fx - fy), -32768, 32767));
    w.blue_yellow = AB_W'(q30_to_field(200 * (fy - fz), -32768, 32767));
    return w;
  endfunction

  // Ordered store of the Lab words the block owes
  class lab_scoreboard;
    lab_word_t owed [$];
    int errors;
    int matched;

    function void note_pixel(pixel_t px);
      owed.insert(owed.size(), convert_pixel(px));
    endfunction

    function void check_word(lab_word_t got);
      lab_word_t want;
      if (owed.size() == 0) begin
        $error("unexpected result word L=%0d a=%0d b=%0d",
               got.lightness, got.green_red, got.blue_yellow);
        errors++;
        return;
      end
      want = owed.pop_front();
      matched++;
      if (got.lightness !== want.lightness) begin
        $error("lightness: expected %0d, got %0d", want.lightness, got.lightness);
        errors++;
      end
      if (got.green_red !== want.green_red) begin
        $error("green_red: expected %0d, got %0d", want.green_red, got.green_red);
        errors++;
      end
      if (got.blue_yellow !== want.blue_yellow) begin
        $error("blue_yellow: expected %0d, got %0d", want.blue_yellow, got.blue_yellow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lab_pix_if in_ch ();
  lab_res_if out_ch ();

  srgb_to_cielab_pixel dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  lab_scoreboard board = new();

  // Idle percentages for each phase; the long output hold overrides the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycles = 0;
  int pixels_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.red = '0;
    in_ch.green = '0;
    in_ch.blue = '0;
    out_ch.ready = 1'b0;
  end

  // Note accepted pixels and check accepted words at each edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_pixel('{in_ch.red, in_ch.green, in_ch.blue});
      if (out_ch.valid && out_ch.ready)
        board.check_word('{out_ch.lightness, out_ch.green_red, out_ch.blue_yellow});
    end
  end

  // Receiver: random stall, or a long hold counted down here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("srgb_to_cielab_pixel_tb: errors");
      $finish;
    end
  end

  // Offer one pixel, honoring the sender idle rate; hold until accepted.
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red <= px.red;
    in_ch.green <= px.green;
    in_ch.blue <= px.blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(3))
      0: px = '{8'($urandom_range(10)), 8'($urandom_range(10)), 8'($urandom_range(10))};
      1: px = '{8'($urandom_range(245, 255)), 8'($urandom_range(245, 255)),
                8'($urandom_range(245, 255))};
      default: px = pixel_t'(24'($urandom));
    endcase
    return px;
  endfunction

  initial begin
    pixel_t directed [$];
    int phase_len;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: black, white, primaries, secondaries, grays around the
    // linear-segment knee and dark colors on the linear f() segment.
    directed = '{
      '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
      '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
      '{8'd10, 8'd10, 8'd10}, '{8'd11, 8'd11, 8'd11}, '{8'd1, 8'd1, 8'd1},
      '{8'd20, 8'd20, 8'd20}, '{8'd128, 8'd128, 8'd128}, '{8'd0, 8'd0, 8'd10},
      '{8'd10, 8'd0, 8'd0}, '{8'd170, 8'd85, 8'd85}, '{8'd85, 8'd170, 8'd85},
      '{8'd0, 8'd255, 8'd1}, '{8'd254, 8'd1, 8'd254}, '{8'd1, 8'd2, 8'd4}
    };
    foreach (directed[i]) send_pixel(directed[i]);

    // Random phases: none, sender idle, receiver stall, both.
    phase_len = RANDOM_PIXELS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 25 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 25 : 0;
      // Hold the receiver off long enough to fill the pipeline and stall input.
      if (ph == 0) hold_cycles <= 3 * PIPE_LAT;
      for (int n = 0; n < phase_len; n++) send_pixel(random_pixel());
    end
    in_ch.valid <= 1'b0;

    // Drain and let any stray word show up.
    while (board.owed.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("sent %0d pixels (primaries, knees, random mixes), %0d Lab words checked",
             pixels_sent, board.matched);
    $display("phases: free run, sender gaps, receiver stalls, both, long output hold");
    if (board.errors == 0) begin
      $display("srgb_to_cielab_pixel_tb: clean");
    end else begin
      $display("srgb_to_cielab_pixel_tb: errors");
    end
    $finish;
  end
endmodule
